>>> rtl/core/servo_and_step_pulse_timer_defines.svh
// Assertion macros shared by the checker of the servo and step pulse timer.
// Depends on nothing; include by bare file name.
`ifndef SERVO_AND_STEP_PULSE_TIMER_DEFINES_SVH
`define SERVO_AND_STEP_PULSE_TIMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSPT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSPT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sspt_pkg.sv
// Types, codes and constants of the servo and step pulse timer.
// Used by every module of the block; depends on nothing.
package sspt_pkg;

  localparam int DEF_NUM_SERVOS  = 6;
  localparam int DEF_FRAME_SLOTS = 20;
  localparam int MAX_SERVOS      = 8;

  localparam int DIV_W      = 16;
  localparam int DEC_W      = 20;
  localparam int EN_W       = 6;
  localparam int SLOTS_W    = 30;
  localparam int SLOT_W     = 5;
  localparam int CFG_DATA_W = 30;
  localparam int CFG_IDX_W  = 2;

  localparam int IDX_W_IN   = 3;
  localparam int WIDTH_W    = 8;
  localparam int TICKS_W    = 16;
  localparam int PRE_W      = 16;
  localparam int PERIOD_W   = 32;
  localparam int CD_W       = 33;
  localparam int COUNT_W    = 32;
  localparam int PINS_W     = 6;
  localparam int FRAME_SUB_W = 7;
  localparam logic [COUNT_W-1:0] ALARM_GUARD = 32'd64;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_READ  = 3'd2,
    ACT_LOAD  = 3'd3,
    ACT_STOP  = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IO_DIV      = 2'd0,
    CFG_STEP_DEC    = 2'd1,
    CFG_SERVO_EN    = 2'd2,
    CFG_FRAME_SLOTS = 2'd3
  } cfg_idx_t;

  // One accepted transaction, decoded. At most one strobe is set.
  typedef struct packed {
    logic                tick;
    logic                wr;
    logic                rd;
    logic                load;
    logic                stop;
    logic [IDX_W_IN-1:0] idx;
    logic [WIDTH_W-1:0]  value;
    logic [TICKS_W-1:0]  ticks;
    logic [PRE_W-1:0]    prescale;
  } cmd_t;

  typedef struct packed {
    logic step_pulse;
    logic step_clear_pulse;
  } step_res_t;

  typedef struct packed {
    logic [PINS_W-1:0]  servo_pins;
    logic               soft_io_strobe;
    logic [WIDTH_W-1:0] read_width;
  } servo_res_t;

endpackage

>>> rtl/core/sspt_step_gen.sv
// Step rate generator: period register, signed countdown and pulse phase.
// Depends on sspt_pkg.
module sspt_step_gen
  import sspt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic [DEC_W-1:0] step_decrement,
  output step_res_t        res
);

  localparam int CALC_W = CD_W + 2;
  // Most negative countdown value, -2^32.
  localparam logic signed [CALC_W-1:0] CD_MIN =
    {{(CALC_W-CD_W){1'b1}}, 1'b1, {(CD_W-1){1'b0}}};

  logic signed [CD_W-1:0] cd_r, cd_nxt;
  logic [PERIOD_W-1:0]    period_r, period_nxt;
  logic                   running_r, running_nxt;
  logic                   phase_clear_r, phase_clear_nxt;

  always_comb begin
    logic signed [CALC_W-1:0] t1;
    logic signed [CALC_W-1:0] t2;
    cd_nxt          = cd_r;
    period_nxt      = period_r;
    running_nxt     = running_r;
    phase_clear_nxt = phase_clear_r;
    res             = '0;
    t1 = {{(CALC_W-CD_W){cd_r[CD_W-1]}}, cd_r}
       - $signed({{(CALC_W-DEC_W){1'b0}}, step_decrement});
    t2 = t1;
    if (cmd.load) begin
      period_nxt  = PERIOD_W'(cmd.ticks) * PERIOD_W'(cmd.prescale);
      running_nxt = 1'b1;
    end
    if (cmd.stop) begin
      running_nxt = 1'b0;
    end
    if (cmd.tick && running_r) begin
      // Expired: issue the edge of the current phase and reload with remainder.
      if (t1[CALC_W-1] || (t1 == {CALC_W{1'b0}})) begin
        if (!phase_clear_r) begin
          res.step_pulse = 1'b1;
        end else begin
          res.step_clear_pulse = 1'b1;
        end
        phase_clear_nxt = !phase_clear_r;
        t2 = t1 + $signed({{(CALC_W-PERIOD_W){1'b0}}, period_r});
      end
      if (t2 < CD_MIN) begin
        t2 = CD_MIN;
      end
      cd_nxt = t2[CD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r          <= '0;
      period_r      <= '0;
      running_r     <= 1'b0;
      phase_clear_r <= 1'b1;
    end else begin
      cd_r          <= cd_nxt;
      period_r      <= period_nxt;
      running_r     <= running_nxt;
      phase_clear_r <= phase_clear_nxt;
    end
  end

endmodule

>>> rtl/core/sspt_servo_gen.sv
// Servo frame generator: soft IO divider, tick counter, frame slots, widths and alarm.
// Depends on sspt_pkg.
module sspt_servo_gen
  import sspt_pkg::*;
#(
  parameter int NUM_SERVOS  = DEF_NUM_SERVOS,
  parameter int FRAME_SLOTS = DEF_FRAME_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [DIV_W-1:0]   io_tick_divider,
  input  logic [EN_W-1:0]    servo_enable_mask,
  input  logic [SLOTS_W-1:0] servo_frame_slots,
  output servo_res_t         res
);

  localparam int IDX_W   = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int FRAME_W = $clog2(FRAME_SLOTS);
  localparam int SVEC_W  = SLOT_W * MAX_SERVOS;

  logic [DIV_W-1:0]   io_cd_r, io_cd_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] alarm_r, alarm_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [WIDTH_W-1:0] widths_r [NUM_SERVOS];
  logic [WIDTH_W-1:0] widths_nxt [NUM_SERVOS];
  logic [NUM_SERVOS-1:0] levels_r, levels_nxt;

  logic [MAX_SERVOS-1:0] en_ext;
  logic [NUM_SERVOS-1:0] en;
  logic [SVEC_W-1:0]     slot_vec;
  logic                  idx_ok;
  logic [IDX_W-1:0]      idx_sel;

  // Servos beyond the configured mask width are never enabled.
  assign en_ext   = MAX_SERVOS'(servo_enable_mask);
  assign en       = en_ext[NUM_SERVOS-1:0];
  assign slot_vec = SVEC_W'(servo_frame_slots);
  assign idx_ok   = ({1'b0, cmd.idx} < 4'(NUM_SERVOS));
  assign idx_sel  = cmd.idx[IDX_W-1:0];

  always_comb begin
    logic                  found;
    logic [WIDTH_W-1:0]    hit_w;
    logic [FRAME_W:0]      fplus;
    logic [MAX_SERVOS-1:0] pins_ext;
    io_cd_nxt  = io_cd_r;
    count_nxt  = count_r;
    alarm_nxt  = alarm_r;
    frame_nxt  = frame_r;
    widths_nxt = widths_r;
    levels_nxt = levels_r;
    res        = '0;
    found      = 1'b0;
    hit_w      = '0;
    fplus      = {1'b0, frame_r} + {{FRAME_W{1'b0}}, 1'b1};

    if (cmd.wr && idx_ok) begin
      widths_nxt[idx_sel] = cmd.value;
    end
    if (cmd.rd && idx_ok && en[idx_sel]) begin
      res.read_width = widths_r[idx_sel];
    end

    if (cmd.tick) begin
      if (io_cd_r <= DIV_W'(1)) begin
        res.soft_io_strobe = 1'b1;
        if (count_r[FRAME_SUB_W-1:0] == '0) begin
          // Lowest enabled servo that owns the current slot wins.
          for (int i = 0; i < NUM_SERVOS; i++) begin
            if (!found && en[i] && (slot_vec[SLOT_W*i +: SLOT_W] == SLOT_W'(frame_r))) begin
              found         = 1'b1;
              hit_w         = widths_r[i];
              levels_nxt[i] = 1'b1;
            end
          end
          if (found) begin
            alarm_nxt = count_r + COUNT_W'(hit_w) + ALARM_GUARD;
          end
          if (fplus >= (FRAME_W+1)'(FRAME_SLOTS)) begin
            frame_nxt = '0;
          end else begin
            frame_nxt = fplus[FRAME_W-1:0];
          end
        end
        if (count_r == alarm_nxt) begin
          levels_nxt = '0;
        end
        count_nxt = count_r + COUNT_W'(1);
        io_cd_nxt = io_tick_divider;
      end else begin
        io_cd_nxt = io_cd_r - DIV_W'(1);
      end
    end

    pins_ext       = MAX_SERVOS'(levels_nxt);
    res.servo_pins = pins_ext[PINS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_cd_r  <= '0;
      count_r  <= '0;
      alarm_r  <= '0;
      frame_r  <= '0;
      widths_r <= '{default: '0};
      levels_r <= '0;
    end else begin
      io_cd_r  <= io_cd_nxt;
      count_r  <= count_nxt;
      alarm_r  <= alarm_nxt;
      frame_r  <= frame_nxt;
      widths_r <= widths_nxt;
      levels_r <= levels_nxt;
    end
  end

endmodule

>>> rtl/core/servo_and_step_pulse_timer.sv
// Top level of the servo and step pulse timer: decode, configuration, output skid.
// Depends on sspt_pkg, sspt_step_gen and sspt_servo_gen.
//
// Usage. Each input transaction carries one action in in_tuser: a tick of the
// fixed-rate timer, a servo width write, a servo width read, a step period load
// (which also starts the step generator) or a stop. Every accepted transaction
// yields exactly one result transaction on the out_ channel, holding the step
// and step-clear edges of a tick, the servo pin levels after the action, the
// soft IO strobe and the width returned by a read.
// An accepted transaction's result is shown on out_tvalid from the next edge on
// if the output register is free, else it waits in the skid register. One
// transaction is taken per cycle while in_tready is high; each action's state
// update fits between input port and result register, step period multiply longest.
// If the receiver stalls, one further transaction is taken into a skid register,
// after which in_tready drops until the receiver takes a result again.
// Reset (rst_n low at a clock edge) clears all timer state and servo widths,
// loads the configuration defaults and empties both output registers.
// Configuration writes on cfg_ take effect at the next edge and should be made
// only while no transaction is in flight.
module servo_and_step_pulse_timer
  import sspt_pkg::*;
#(
  parameter int NUM_SERVOS  = DEF_NUM_SERVOS,
  parameter int FRAME_SLOTS = DEF_FRAME_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata, low bit up: servo_index[2:0], servo_value[10:3],
  // step_ticks[26:11], step_prescale[42:27], zero fill[47:43].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: action[2:0].
  input  logic [2:0]             in_tuser,
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata, low bit up: step_pulse[0], step_clear_pulse[1], servo_pins[7:2],
  // soft_io_strobe[8], read_width[16:9], zero fill[23:17].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers.
  logic [DIV_W-1:0]   io_div_r;
  logic [DEC_W-1:0]   step_dec_r;
  logic [EN_W-1:0]    servo_en_r;
  logic [SLOTS_W-1:0] frame_slots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_div_r      <= DIV_W'(1);
      step_dec_r    <= DEC_W'(4);
      servo_en_r    <= '0;
      frame_slots_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IO_DIV:      io_div_r      <= cfg_wdata[DIV_W-1:0];
        CFG_STEP_DEC:    step_dec_r    <= cfg_wdata[DEC_W-1:0];
        CFG_SERVO_EN:    servo_en_r    <= cfg_wdata[EN_W-1:0];
        CFG_FRAME_SLOTS: frame_slots_r <= cfg_wdata[SLOTS_W-1:0];
      endcase
    end
  end

  // Decode of the accepted transaction. Unused action codes set no strobe,
  // so they leave all state alone and still produce a result.
  logic accept;
  cmd_t cmd;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    cmd          = '0;
    cmd.idx      = in_tdata[2:0];
    cmd.value    = in_tdata[10:3];
    cmd.ticks    = in_tdata[26:11];
    cmd.prescale = in_tdata[42:27];
    if (accept) begin
      unique case (action_t'(in_tuser))
        ACT_TICK:  cmd.tick = 1'b1;
        ACT_WRITE: cmd.wr   = 1'b1;
        ACT_READ:  cmd.rd   = 1'b1;
        ACT_LOAD:  cmd.load = 1'b1;
        ACT_STOP:  cmd.stop = 1'b1;
        default:   ;
      endcase
    end
  end

  step_res_t  step_res;
  servo_res_t servo_res;

  sspt_step_gen u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .step_decrement (step_dec_r),
    .res            (step_res)
  );

  sspt_servo_gen #(
    .NUM_SERVOS  (NUM_SERVOS),
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_servo (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .io_tick_divider   (io_div_r),
    .servo_enable_mask (servo_en_r),
    .servo_frame_slots (frame_slots_r),
    .res               (servo_res)
  );

  // Result of this transaction, packed for the output channel.
  logic [OUT_TDATA_W-1:0] res_data;

  assign res_data = {7'd0, servo_res.read_width, servo_res.soft_io_strobe,
                     servo_res.servo_pins, step_res.step_clear_pulse,
                     step_res.step_pulse};

  // Output register plus one skid register. The skid holds a result that
  // arrived while the output register was stalled.
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic [OUT_TDATA_W-1:0] skid_data_r, skid_data_nxt;

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        if (accept) begin
          out_data_nxt = res_data;
        end
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

>>> rtl/core/sspt_checker.sv
// Port-level checker of the servo and step pulse timer, bound to the top level.
// Depends on sspt_pkg and servo_and_step_pulse_timer_defines.svh.
`include "servo_and_step_pulse_timer_defines.svh"

module sspt_checker
  import sspt_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  `SSPT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // A tick issues a step edge or a step-clear edge, never both.
  `SSPT_ASSERT_IMP(a_one_step_edge, clk, rst_n, out_tvalid, !(out_tdata[0] && out_tdata[1]), "step and step-clear edges together")

  // A nonzero read width comes from a read, which carries no tick flags.
  `SSPT_ASSERT_IMP(a_read_not_tick, clk, rst_n, out_tvalid && (out_tdata[16:9] != 8'd0), (out_tdata[8] == 1'b0) && (out_tdata[1:0] == 2'b00), "read result carries tick flags")

  // The input side only backs off after a stall on the result side.
  `SSPT_ASSERT_IMP(a_stall_cause, clk, rst_n, $fell(in_tready), $past(out_tvalid && !out_tready), "in_tready dropped without output stall")

endmodule

bind servo_and_step_pulse_timer sspt_checker u_sspt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
